### hw/rtl/circular_list_engine_top_macros.svh
`ifndef CIRCULAR_LIST_ENGINE_TOP_MACROS_SVH
`define CIRCULAR_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

    localparam int VALUE_W = 32;
    localparam int FIELD_CNT_W = 5;

    localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
    localparam logic [2:0] FUNC_INS_BACK  = 3'd1;
    localparam logic [2:0] FUNC_REMOVE    = 3'd2;
    localparam logic [2:0] FUNC_CLEAR     = 3'd3;
    localparam logic [2:0] FUNC_READ      = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]                func;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        logic                      last;
        logic [1:0]                status;
        logic [FIELD_CNT_W-1:0]    entry_count;
        logic [FIELD_CNT_W-1:0]    removed_count;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/circular_list_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of signed 32-bit values in a ring store of CAPACITY entries.
// Command channel: cmd (func, value) transfers at a clock edge with start high
// and busy low. Result channel: result transfers in every cycle that strobe is
// high; the receiver cannot stall, so every result is taken when shown.
// Insert front/back, clear and unused codes: one result, in the cycle after the
// transfer; busy stays low, so a command may follow in the next cycle.
// Remove all equal: one store word read and compared per cycle; busy while the
// N held entries are walked, the result shown in the cycle in which busy drops.
// Read out: busy while the N entries are read; they stream one per cycle,
// registered after the store read, the final one marked with last.
// The single read port of the ring store sets the pace of read out and remove.
// An empty list answers remove, clear and read out with one empty-status
// result; an insert into a full store is refused with full status.
// Reset empties the list and puts the head at slot 0; store contents are not
// cleared, since only held entries are ever read.
module circular_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cle_pkg::cmd_t    cmd,
    output logic                  strobe,
    output cle_pkg::result_t      result
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = CNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_READ
    } state_t;

    state_t                      state_reg,  state_next;
    logic [ADDR_W-1:0]           head_reg,   head_next;
    logic [CNT_W-1:0]            count_reg,  count_next;
    logic [CNT_W-1:0]            idx_reg,    idx_next;
    logic [CNT_W-1:0]            kept_reg,   kept_next;
    logic                        vld_reg,    vld_next;
    logic [cle_pkg::VALUE_W-1:0] value_reg,  value_next;
    logic                        strobe_reg, strobe_next;
    cle_pkg::result_t            result_reg, result_next;

    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [cle_pkg::VALUE_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [cle_pkg::VALUE_W-1:0] mem_rdata;

    logic [ADDR_W-1:0]           head_dec;
    logic [CNT_W-1:0]            wr_off;
    logic [SUM_W-1:0]            rd_sum;
    logic [SUM_W-1:0]            wr_sum;
    logic [ADDR_W-1:0]           rd_slot;
    logic [ADDR_W-1:0]           wr_slot;
    logic                        issue_en;
    logic                        is_full;
    logic                        is_empty;
    logic [CNT_W-1:0]            removed;

    // ring address unit: head plus offset, wrapped once
    always_comb
    begin
        wr_off = (state_reg == S_WALK) ? kept_reg : count_reg;
        rd_sum = SUM_W'(head_reg) + SUM_W'(idx_reg);
        wr_sum = SUM_W'(head_reg) + SUM_W'(wr_off);
        if (rd_sum >= SUM_W'(CAPACITY))
        begin
            rd_sum = rd_sum - SUM_W'(CAPACITY);
        end
        if (wr_sum >= SUM_W'(CAPACITY))
        begin
            wr_sum = wr_sum - SUM_W'(CAPACITY);
        end
        rd_slot  = rd_sum[ADDR_W-1:0];
        wr_slot  = wr_sum[ADDR_W-1:0];
        head_dec = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - 1'b1;
    end

    assign issue_en = (idx_reg < count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign removed  = count_reg - kept_reg;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        kept_next   = kept_reg;
        value_next  = value_reg;
        mem_we      = 1'b0;
        mem_waddr   = wr_slot;
        mem_wdata   = cmd.value;
        mem_re      = 1'b0;
        strobe_next = 1'b0;
        result_next = '0;
        result_next.last        = 1'b1;
        result_next.status      = cle_pkg::ST_OK;
        result_next.entry_count = cle_pkg::FIELD_CNT_W'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    case (cmd.func)
                        cle_pkg::FUNC_INS_FRONT,
                        cle_pkg::FUNC_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                result_next.status = cle_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (cmd.func == cle_pkg::FUNC_INS_FRONT)
                                begin
                                    head_next = head_dec;
                                    mem_waddr = head_dec;
                                end
                                count_next = CNT_W'(count_reg + 1'b1);
                                result_next.entry_count =
                                    cle_pkg::FIELD_CNT_W'(count_next);
                            end
                        end
                        cle_pkg::FUNC_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = cle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                state_next  = S_WALK;
                                idx_next    = '0;
                                kept_next   = '0;
                                value_next  = cmd.value;
                            end
                        end
                        cle_pkg::FUNC_CLEAR:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = cle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = '0;
                                result_next.entry_count = '0;
                            end
                        end
                        cle_pkg::FUNC_READ:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = cle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                state_next  = S_READ;
                                idx_next    = '0;
                            end
                        end
                        default:
                        begin
                            result_next.status = cle_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                mem_re = issue_en;
                if (issue_en)
                begin
                    idx_next = CNT_W'(idx_reg + 1'b1);
                end
                // compact survivors toward the front
                if (vld_reg && (mem_rdata != value_reg))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    kept_next = CNT_W'(kept_reg + 1'b1);
                end
                if (!issue_en && !vld_reg)
                begin
                    state_next  = S_IDLE;
                    count_next  = kept_reg;
                    strobe_next = 1'b1;
                    result_next.entry_count   = cle_pkg::FIELD_CNT_W'(kept_reg);
                    result_next.removed_count = cle_pkg::FIELD_CNT_W'(removed);
                    result_next.status = (removed == '0) ? cle_pkg::ST_NOTFOUND
                                                         : cle_pkg::ST_OK;
                end
            end

            S_READ:
            begin
                mem_re = issue_en;
                if (issue_en)
                begin
                    idx_next = CNT_W'(idx_reg + 1'b1);
                end
                if (vld_reg)
                begin
                    strobe_next             = 1'b1;
                    result_next.entry_value = mem_rdata;
                    result_next.last        = !issue_en;
                    if (!issue_en)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        vld_next = mem_re;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            kept_reg   <= '0;
            vld_reg    <= 1'b0;
            value_reg  <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            kept_reg   <= kept_next;
            vld_reg    <= vld_next;
            value_reg  <= value_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    cle_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (rd_slot),
        .rd_data (mem_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hw/rtl/cle_store.sv
`timescale 1ns / 1ps
`default_nettype none

module cle_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [cle_pkg::VALUE_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic [cle_pkg::VALUE_W-1:0]      rd_data
);

    logic [cle_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cle_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "circular_list_engine_top_macros.svh"

module cle_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire cle_pkg::cmd_t    cmd,
    input wire logic             strobe,
    input wire cle_pkg::result_t result
);

    `CLE_ASSERT_NEXT(a_insert_answers, start && !busy && (cmd.func == cle_pkg::FUNC_INS_FRONT || cmd.func == cle_pkg::FUNC_INS_BACK), strobe && result.last && !busy, "insert transfer without a single result")
    `CLE_ASSERT_NOW(a_stream_busy, strobe && !result.last, busy, "read out entry shown after engine went idle")
    `CLE_ASSERT_NOW(a_error_single, strobe && (result.status != cle_pkg::ST_OK), result.last && (result.entry_value == '0), "error status on a non-final or valued result")
    `CLE_ASSERT_NOW(a_removed_final, strobe && (result.removed_count != '0), result.last && (result.status == cle_pkg::ST_OK), "removed count on a wrong result")

endmodule

bind circular_list_engine_top cle_checker u_cle_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire
